// File: sv/bcc_pkg.sv
`timescale 1ns / 1ps
// bcc_pkg: shared types and constants for the button click classifier
// depends on nothing; used by bcc_fsm and button_click_classifier

package bcc_pkg;

   localparam int COUNT_WIDTH = 16;
   // compare width wide enough for the count and the 16-bit limits
   localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_TICKS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_TICKS     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TICKS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM_TICKS  = 3'd4;

   localparam logic        RST_ACTIVE_LEVEL   = 1'b1;
   localparam logic [15:0] RST_DEBOUNCE_TICKS = 16'd30;
   localparam logic [15:0] RST_LONG_TICKS     = 16'd30000;
   localparam logic [15:0] RST_WINDOW_TICKS   = 16'd4000;
   localparam logic [7:0]  RST_CONFIRM_TICKS  = 8'd10;

   localparam logic [1:0] KIND_BOUNCE = 2'd0;
   localparam logic [1:0] KIND_SINGLE = 2'd1;
   localparam logic [1:0] KIND_DOUBLE = 2'd2;
   localparam logic [1:0] KIND_LONG   = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HOLD    = 2'd1,
      PH_GAP     = 2'd2,
      PH_CONFIRM = 2'd3
   } phase_type;

   typedef struct packed {
      logic        active_level;
      logic [15:0] debounce_ticks;
      logic [15:0] long_ticks;
      logic [15:0] window_ticks;
      logic [7:0]  confirm_ticks;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
   } result_type;

endpackage

// File: sv/bcc_fsm.sv
`timescale 1ns / 1ps
// bcc_fsm: press classification state machine, one sample per accepted word
// depends on bcc_pkg

module bcc_fsm (
   input  logic              clock,
   input  logic              reset,
   input  logic              sample_accept,
   input  logic              sample_level,
   input  bcc_pkg::cfg_type  cfg,
   output bcc_pkg::result_type result
);

   localparam int CW = bcc_pkg::COUNT_WIDTH;
   localparam int XW = bcc_pkg::CMP_W;

   bcc_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [7:0]         confirm_ff, confirm_in;
   logic               prev_ff, prev_in;

   logic               pressed;
   logic               was_pressed;
   logic [CW-1:0]      count_inc;
   logic [CW-1:0]      count_span;
   logic [CW-1:0]      count_span_inc;

   // saturating add, clamps at the all-ones count
   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
   endfunction

   assign pressed        = (sample_level == cfg.active_level);
   assign was_pressed    = (prev_ff == cfg.active_level);
   assign count_inc      = sat_add(count_ff, CW'(1));
   assign count_span     = sat_add(count_ff, CW'(cfg.confirm_ticks));
   assign count_span_inc = sat_add(count_span, CW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= bcc_pkg::PH_IDLE;
         count_ff   <= '0;
         confirm_ff <= '0;
         prev_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         confirm_ff <= confirm_in;
         prev_ff    <= prev_in;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      confirm_in   = confirm_ff;
      prev_in      = prev_ff;
      result.valid = 1'b0;
      result.kind  = bcc_pkg::KIND_BOUNCE;
      if (sample_accept) begin
         prev_in = sample_level;
         unique case (phase_ff)
            bcc_pkg::PH_IDLE: begin
               // arming sample is the first held sample
               if (pressed && !was_pressed) begin
                  phase_in = bcc_pkg::PH_HOLD;
                  count_in = CW'(1);
               end
            end
            bcc_pkg::PH_HOLD: begin
               if (!pressed) begin
                  if (XW'(count_ff) < XW'(cfg.debounce_ticks)) begin
                     result.valid = 1'b1;
                     result.kind  = bcc_pkg::KIND_BOUNCE;
                     phase_in     = bcc_pkg::PH_IDLE;
                  end else if (XW'(count_ff) > XW'(cfg.window_ticks)) begin
                     result.valid = 1'b1;
                     result.kind  = bcc_pkg::KIND_SINGLE;
                     phase_in     = bcc_pkg::PH_IDLE;
                  end else begin
                     // release sample opens the gap
                     phase_in = bcc_pkg::PH_GAP;
                     count_in = count_inc;
                  end
               end else if (XW'(count_ff) > XW'(cfg.long_ticks)) begin
                  result.valid = 1'b1;
                  result.kind  = bcc_pkg::KIND_LONG;
                  phase_in     = bcc_pkg::PH_IDLE;
               end else begin
                  count_in = count_inc;
               end
            end
            bcc_pkg::PH_GAP: begin
               if (pressed) begin
                  confirm_in = (cfg.confirm_ticks == 8'd0) ? 8'd1 : cfg.confirm_ticks;
                  phase_in   = bcc_pkg::PH_CONFIRM;
               end else if (XW'(count_ff) > XW'(cfg.window_ticks)) begin
                  result.valid = 1'b1;
                  result.kind  = bcc_pkg::KIND_SINGLE;
                  phase_in     = bcc_pkg::PH_IDLE;
               end else begin
                  count_in = count_inc;
               end
            end
            bcc_pkg::PH_CONFIRM: begin
               if (confirm_ff > 8'd1) begin
                  confirm_in = confirm_ff - 8'd1;
               end else begin
                  confirm_in = 8'd0;
                  if (pressed) begin
                     result.valid = 1'b1;
                     result.kind  = bcc_pkg::KIND_DOUBLE;
                     phase_in     = bcc_pkg::PH_IDLE;
                  end else if (XW'(count_span) > XW'(cfg.window_ticks)) begin
                     result.valid = 1'b1;
                     result.kind  = bcc_pkg::KIND_SINGLE;
                     phase_in     = bcc_pkg::PH_IDLE;
                  end else begin
                     count_in = count_span_inc;
                     phase_in = bcc_pkg::PH_GAP;
                  end
               end
            end
            default: begin
               phase_in = bcc_pkg::PH_IDLE;
            end
         endcase
      end
   end

endmodule

// File: sv/button_click_classifier.sv
`timescale 1ns / 1ps
// button_click_classifier: top level, csr bank, classifier and output buffer
// depends on bcc_pkg and bcc_fsm
//
// usage
//  - req channel: one word per 100 us tick, req_button_level is the raw pin
//    sample; a word moves when req_valid is high and req_stall is low
//  - rsp channel: rsp_click_kind 0 bounce, 1 single, 2 double, 3 long; a
//    word is produced only on the sample that settles a press, never more
//    than one per sample
//  - csr channel: csr_index selects the register (0 active level,
//    1 debounce, 2 long, 3 window, 4 confirm); csr_ready is always high;
//    writes must be made only while the block is idle; this is not enforced
//  - output path: the result of a taken sample word is registered into the
//    output register, or into the skid word while the output word is stalled
//  - throughput: one sample word a cycle bar stalls; the whole classification step
//    is one pass of compares and saturating adds ahead of the state register
//  - stall: the output register plus a one-word skid buffer keep req open
//    while a result waits; req_stall rises only once the skid word is full
//  - reset: synchronous, active high; state returns to idle, the previous
//    sample is taken as released, registers return to their defaults and
//    both output words are emptied

module button_click_classifier (
   input  logic                            clock,
   input  logic                            reset,
   // sample channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_button_level,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_click_kind,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bcc_pkg::CSR_DATA_W-1:0]  csr_data
);

   bcc_pkg::cfg_type    cfg_ff, cfg_in;
   bcc_pkg::result_type fsm_result;

   logic       req_accept;
   logic       rsp_drain;

   // output register and skid word
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic       skid_valid_ff, skid_valid_in;
   logic [1:0] skid_kind_ff, skid_kind_in;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_drain  = out_valid_ff && !rsp_stall;

   // register bank
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bcc_pkg::CSR_ACTIVE_LEVEL:   cfg_in.active_level   = csr_data[0];
            bcc_pkg::CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_data;
            bcc_pkg::CSR_LONG_TICKS:     cfg_in.long_ticks     = csr_data;
            bcc_pkg::CSR_WINDOW_TICKS:   cfg_in.window_ticks   = csr_data;
            bcc_pkg::CSR_CONFIRM_TICKS:  cfg_in.confirm_ticks  = csr_data[7:0];
            default:                     cfg_in = cfg_ff;   // unmapped index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level   <= bcc_pkg::RST_ACTIVE_LEVEL;
         cfg_ff.debounce_ticks <= bcc_pkg::RST_DEBOUNCE_TICKS;
         cfg_ff.long_ticks     <= bcc_pkg::RST_LONG_TICKS;
         cfg_ff.window_ticks   <= bcc_pkg::RST_WINDOW_TICKS;
         cfg_ff.confirm_ticks  <= bcc_pkg::RST_CONFIRM_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classification state machine
   bcc_fsm u_fsm (
      .clock         (clock),
      .reset         (reset),
      .sample_accept (req_accept),
      .sample_level  (req_button_level),
      .cfg           (cfg_ff),
      .result        (fsm_result)
   );

   // output buffer: the skid word drains first, new results fill the gap
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      skid_valid_in = skid_valid_ff;
      skid_kind_in  = skid_kind_ff;
      if (rsp_drain || !out_valid_ff) begin
         if (skid_valid_ff) begin
            // no sample is taken while the skid word is full
            out_valid_in  = 1'b1;
            out_kind_in   = skid_kind_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = fsm_result.valid;
            out_kind_in  = fsm_result.kind;
         end
      end else if (fsm_result.valid) begin
         // output held by the receiver, park the new word
         skid_valid_in = 1'b1;
         skid_kind_in  = fsm_result.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff  <= out_kind_in;
      skid_kind_ff <= skid_kind_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_click_kind = out_kind_ff;

`ifndef SYNTHESIS
   // the skid word is only ever filled behind a waiting output word
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   // a result only comes from an accepted sample
   assert property (@(posedge clock) disable iff (reset)
      fsm_result.valid |-> req_accept)
      else $error("result produced without an accepted sample");

   // a result arriving behind a stalled output word is parked, not lost
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && fsm_result.valid) |=> skid_valid_ff)
      else $error("result dropped while output stalled");
`endif

endmodule
